[hdl/lfre_pkg.sv]
// Shared types and constants for the layer fade ramp engine.
`timescale 1ns / 1ps

package lfre_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TICK_MUL,
    ST_TICK_DIV,
    ST_TICK_FIN,
    ST_PRE,
    ST_SB_MUL,
    ST_SB_FIN,
    ST_SS_MUL,
    ST_SS_FIN,
    ST_GOAL,
    ST_BRANCH,
    ST_SLEW,
    ST_IP_MUL,
    ST_IP_DIV,
    ST_IP_FIN,
    ST_APPLY,
    ST_PUBLISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_TICK,
    MUL_SCALE_B,
    MUL_SCALE_S,
    MUL_INTERP
  } mul_sel_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STYLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_UNRESP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNRESP_BPCT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNRESP_SPCT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PSAT_OK     = 3'd6;

  localparam logic [1:0] CH_OPA = 2'd0;
  localparam logic [1:0] CH_BRI = 2'd1;
  localparam logic [1:0] CH_SAT = 2'd2;

  localparam logic [15:0] MODAL_BRIGHT = 16'hA8A8;
  localparam logic [15:0] STEP_MIN     = 16'd12;
  // ceil(2^30/100): x/100 = (x*R)>>30 for x below 2^23
  localparam logic [23:0] PCT_RECIP    = 24'd10737419;
  localparam logic [6:0]  PCT_FULL     = 7'd100;
  // ceil(2^20/12): x/12 = (x*R)>>20 and x/6 = (x*R)>>19 for 16-bit x
  localparam logic [16:0] RECIP_12     = 17'd87382;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    mul_sel_t mul_sel;
    logic     tick_fin;
    logic     pre;
    logic     scale_b_fin;
    logic     scale_s_fin;
    logic     goal;
    logic     slew;
    logic     ip_fin;
    logic     apply;
    logic     publish;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic req_paint;
    logic mode;
    logic period_zero;
    logic dur_zero;
    logic idle_paint;
    logic need_sb;
    logic need_ss;
    logic step_nz;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[hdl/lfre_div.sv]
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module lfre_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [31:0] quo;
  logic [16:0] trial;
  logic        ge;

  assign trial    = {rem, quo[31]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

[hdl/lfre_dp.sv]
// Datapath: configuration, channel state, shared multiplier and divider, output register.
`timescale 1ns / 1ps

module lfre_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lfre_pkg::cmd_t                cmd,
  output lfre_pkg::status_t             sts,
  input  logic                          cfg_we,
  input  logic [lfre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfre_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          req_type,
  input  logic [15:0]                   elapsed_ms,
  input  logic [15:0]                   req_opacity,
  input  logic [15:0]                   req_brightness,
  input  logic [15:0]                   req_saturation,
  input  logic                          owner_alive,
  input  logic                          modal_active,
  input  logic                          layer_is_modal,
  input  logic                          closing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_opacity,
  output logic [15:0]                   out_brightness,
  output logic [15:0]                   out_saturation,
  output logic                          needs_repaint,
  output logic                          stopped
);

  // configuration
  logic        ramp_style;
  logic [15:0] period_ms;
  logic [15:0] duration_ms;
  logic        dim_unresp;
  logic [6:0]  pct_b;
  logic [6:0]  pct_s;
  logic        psat_ok;

  // captured item
  logic        in_paint;
  logic [15:0] in_elapsed, in_o, in_b, in_s;
  logic        in_alive, in_modal, in_self_modal, in_closing;

  // channel state
  logic [15:0] cur_o, cur_b, cur_s;
  logic [15:0] goal_o, goal_b, goal_s;
  logic signed [16:0] delta_o, delta_b, delta_s;
  logic [15:0] step_size;
  logic [15:0] time_left;

  // working registers
  logic [15:0] tgt_o, tgt_b, tgt_s;
  logic [15:0] res_o, res_b, res_s;
  logic        res_o_pos;
  logic        rp, stp;
  logic [12:0] st12;
  logic [13:0] st6;
  logic [22:0] sc_prod;

  logic [15:0] mul_a, mul_b, divisor;
  logic [31:0] product, quotient;
  logic        div_done;
  logic        dim_path;
  logic [15:0] eff_s;
  logic [32:0] recip_p;
  logic [15:0] q_sat;
  logic [46:0] sc_p;
  logic [15:0] sc_sat;

  logic signed [16:0] ip_delta;
  logic [15:0] ip_tgt, ip_mag, ip_val;
  logic [31:0] ip_q;
  logic signed [33:0] ip_v;

  logic [15:0] tick_st;
  logic [15:0] sl_o, sl_b, sl_s;
  logic [15:0] def_b, def_s;

  function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] tgt,
                                       input logic [15:0] st);
    logic [16:0] up;
    logic [15:0] dn;
    up = {1'b0, cur} + {1'b0, st};
    dn = (st >= cur) ? 16'd0 : cur - st;
    if (tgt > cur) slew = (up > {1'b0, tgt}) ? tgt : up[15:0];
    else if (tgt < cur) slew = (dn < tgt) ? tgt : dn;
    else slew = cur;
  endfunction

  assign dim_path = !in_alive && dim_unresp;
  assign eff_s    = psat_ok ? cur_s : in_s;

  always_comb begin
    case (cmd.ch)
      lfre_pkg::CH_OPA: begin ip_delta = delta_o; ip_tgt = tgt_o; end
      lfre_pkg::CH_BRI: begin ip_delta = delta_b; ip_tgt = tgt_b; end
      default:          begin ip_delta = delta_s; ip_tgt = tgt_s; end
    endcase
  end
  assign ip_mag = ip_delta[16] ? 16'(-ip_delta) : ip_delta[15:0];

  // the divider is idle during percent scaling
  always_comb begin
    case (cmd.mul_sel)
      lfre_pkg::MUL_TICK: begin
        mul_a = in_elapsed; mul_b = 16'hFFFF; divisor = period_ms;
      end
      lfre_pkg::MUL_SCALE_B: begin
        mul_a = tgt_b; mul_b = {9'd0, pct_b}; divisor = period_ms;
      end
      lfre_pkg::MUL_SCALE_S: begin
        mul_a = tgt_s; mul_b = {9'd0, pct_s}; divisor = period_ms;
      end
      default: begin
        mul_a = ip_mag; mul_b = time_left; divisor = duration_ms;
      end
    endcase
  end
  assign product = mul_a * mul_b;

  lfre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_sat   = (|quotient[31:16]) ? 16'hFFFF : quotient[15:0];
  assign tick_st = (period_ms == 16'd0) ? 16'hFFFF : q_sat;

  // percent scaling: registered value*pct divided by 100 through the reciprocal
  assign sc_p   = 47'(sc_prod) * 47'(lfre_pkg::PCT_RECIP);
  assign sc_sat = sc_p[46] ? 16'hFFFF : sc_p[45:30];

  // interpolation: target minus delta*time_left/duration, truncated toward zero
  assign ip_q = (duration_ms == 16'd0) ? 32'd0 : quotient;
  assign ip_v = ip_delta[16] ? $signed({18'd0, ip_tgt}) + $signed({2'b00, ip_q})
                             : $signed({18'd0, ip_tgt}) - $signed({2'b00, ip_q});
  assign ip_val = ip_v[33] ? 16'd0 : ((|ip_v[32:16]) ? 16'hFFFF : ip_v[15:0]);

  assign recip_p = 33'(step_size) * 33'(lfre_pkg::RECIP_12);
  assign sl_o = slew(cur_o, tgt_o, step_size);
  assign sl_b = slew(cur_b, tgt_b, {3'd0, st12});
  assign sl_s = slew(cur_s, tgt_s, {2'd0, st6});

  always_comb begin
    def_b = in_b;
    def_s = in_s;
    if (!dim_path && in_modal && !in_self_modal) begin
      def_b = lfre_pkg::MODAL_BRIGHT;
      def_s = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_style  <= 1'b0;
      period_ms   <= 16'd100;
      duration_ms <= 16'd100;
      dim_unresp  <= 1'b0;
      pct_b       <= 7'd65;
      pct_s       <= 7'd0;
      psat_ok     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lfre_pkg::CFG_RAMP_STYLE:  ramp_style  <= cfg_data[0];
        lfre_pkg::CFG_PERIOD:      period_ms   <= cfg_data[15:0];
        lfre_pkg::CFG_DURATION:    duration_ms <= cfg_data[15:0];
        lfre_pkg::CFG_DIM_UNRESP:  dim_unresp  <= cfg_data[0];
        lfre_pkg::CFG_UNRESP_BPCT: pct_b       <= cfg_data[6:0];
        lfre_pkg::CFG_UNRESP_SPCT: pct_s       <= cfg_data[6:0];
        lfre_pkg::CFG_PSAT_OK:     psat_ok     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_paint      <= req_type;
      in_elapsed    <= elapsed_ms;
      in_o          <= req_opacity;
      in_b          <= req_brightness;
      in_s          <= req_saturation;
      in_alive      <= owner_alive;
      in_modal      <= modal_active;
      in_self_modal <= layer_is_modal;
      in_closing    <= closing;
    end
    st12    <= recip_p[32:20];
    st6     <= recip_p[32:19];
    sc_prod <= product[22:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_o <= 16'hFFFF; cur_b <= 16'hFFFF; cur_s <= 16'hFFFF;
      goal_o <= 16'hFFFF; goal_b <= 16'hFFFF; goal_s <= 16'hFFFF;
      delta_o <= '0; delta_b <= '0; delta_s <= '0;
      step_size <= '0;
      time_left <= '0;
    end else begin
      if (cmd.tick_fin) begin
        if (!ramp_style) begin
          step_size <= (tick_st < lfre_pkg::STEP_MIN) ? lfre_pkg::STEP_MIN : tick_st;
          time_left <= '0;
        end else if (time_left != 16'd0) begin
          step_size <= 16'd1;
          time_left <= (in_elapsed >= time_left) ? 16'd0 : time_left - in_elapsed;
        end else begin
          step_size <= '0;
        end
      end
      if (cmd.pre && !psat_ok) cur_s <= in_s;
      if (cmd.goal && ramp_style &&
          (tgt_o != goal_o || tgt_b != goal_b || tgt_s != goal_s)) begin
        time_left <= duration_ms;
        step_size <= 16'd1;
        delta_o   <= $signed({1'b0, tgt_o}) - $signed({1'b0, cur_o});
        delta_b   <= $signed({1'b0, tgt_b}) - $signed({1'b0, cur_b});
        delta_s   <= $signed({1'b0, tgt_s}) - $signed({1'b0, cur_s});
        goal_o    <= tgt_o;
        goal_b    <= tgt_b;
        goal_s    <= tgt_s;
      end
      if (cmd.apply) begin
        step_size <= '0;
        if (res_o_pos) begin
          cur_o <= res_o;
          cur_b <= res_b;
          cur_s <= res_s;
        end else begin
          cur_o <= 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pre) begin
      tgt_o <= in_closing ? 16'd0 : in_o;
      tgt_b <= def_b;
      tgt_s <= def_s;
      rp    <= 1'b0;
      stp   <= 1'b0;
    end
    if (cmd.scale_b_fin) tgt_b <= sc_sat;
    if (cmd.scale_s_fin) tgt_s <= sc_sat;
    if (cmd.slew) begin
      res_o     <= sl_o;
      res_o_pos <= sl_o != 16'd0;
      res_b     <= sl_b;
      res_s     <= sl_s;
    end
    if (cmd.ip_fin) begin
      case (cmd.ch)
        lfre_pkg::CH_OPA: begin
          res_o     <= ip_val;
          res_o_pos <= !ip_v[33] && (ip_v != 34'sd0);
        end
        lfre_pkg::CH_BRI: res_b <= ip_val;
        default:          res_s <= ip_val;
      endcase
    end
    if (cmd.apply) begin
      if (res_o_pos) rp <= (res_o != tgt_o) || (res_b != tgt_b) || (res_s != tgt_s);
      else stp <= 1'b1;
    end
  end

  // output register: a new item may be loaded in the cycle the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_opacity    <= cur_o;
      out_brightness <= cur_b;
      out_saturation <= cur_s;
      needs_repaint  <= rp;
      stopped        <= stp;
    end
  end

  always_comb begin
    sts.req_paint   = in_paint;
    sts.mode        = ramp_style;
    sts.period_zero = period_ms == 16'd0;
    sts.dur_zero    = duration_ms == 16'd0;
    sts.idle_paint  = in_alive && !in_closing && !in_modal &&
                      cur_o == in_o && cur_b == in_b && eff_s == in_s;
    sts.need_sb     = dim_path && pct_b != lfre_pkg::PCT_FULL;
    sts.need_ss     = dim_path && pct_s != lfre_pkg::PCT_FULL && psat_ok;
    sts.step_nz     = step_size != 16'd0;
    sts.div_done    = div_done;
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

[hdl/lfre_ctrl.sv]
// Controller: sequences tick and paint items through the datapath.
`timescale 1ns / 1ps

module lfre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lfre_pkg::status_t sts,
  output lfre_pkg::cmd_t    cmd
);

  lfre_pkg::state_t state, state_next;
  logic [1:0] ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfre_pkg::ST_IDLE;
      ch    <= lfre_pkg::CH_OPA;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    cmd.mul_sel = lfre_pkg::MUL_TICK;
    in_ready   = 1'b0;
    case (state)
      lfre_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = lfre_pkg::ST_PRE;
        end
      end
      lfre_pkg::ST_PRE: begin
        // a tick is routed off here, once the item sits in the datapath
        if (!sts.req_paint) begin
          state_next = lfre_pkg::ST_TICK_MUL;
        end else begin
          cmd.pre = 1'b1;
          if (sts.idle_paint)   state_next = lfre_pkg::ST_PUBLISH;
          else if (sts.need_sb) state_next = lfre_pkg::ST_SB_MUL;
          else if (sts.need_ss) state_next = lfre_pkg::ST_SS_MUL;
          else                  state_next = lfre_pkg::ST_GOAL;
        end
      end
      lfre_pkg::ST_TICK_MUL: begin
        if (!sts.mode && !sts.period_zero) begin
          cmd.div_start = 1'b1;
          state_next    = lfre_pkg::ST_TICK_DIV;
        end else begin
          state_next = lfre_pkg::ST_TICK_FIN;
        end
      end
      lfre_pkg::ST_TICK_DIV: begin
        if (sts.div_done) state_next = lfre_pkg::ST_TICK_FIN;
      end
      lfre_pkg::ST_TICK_FIN: begin
        cmd.tick_fin = 1'b1;
        state_next   = lfre_pkg::ST_IDLE;
      end
      lfre_pkg::ST_SB_MUL: begin
        cmd.mul_sel = lfre_pkg::MUL_SCALE_B;
        state_next  = lfre_pkg::ST_SB_FIN;
      end
      lfre_pkg::ST_SB_FIN: begin
        cmd.scale_b_fin = 1'b1;
        state_next = sts.need_ss ? lfre_pkg::ST_SS_MUL : lfre_pkg::ST_GOAL;
      end
      lfre_pkg::ST_SS_MUL: begin
        cmd.mul_sel = lfre_pkg::MUL_SCALE_S;
        state_next  = lfre_pkg::ST_SS_FIN;
      end
      lfre_pkg::ST_SS_FIN: begin
        cmd.scale_s_fin = 1'b1;
        state_next      = lfre_pkg::ST_GOAL;
      end
      lfre_pkg::ST_GOAL: begin
        cmd.goal   = 1'b1;
        state_next = lfre_pkg::ST_BRANCH;
      end
      lfre_pkg::ST_BRANCH: begin
        ch_next = lfre_pkg::CH_OPA;
        if (!sts.step_nz)  state_next = lfre_pkg::ST_PUBLISH;
        else if (sts.mode) state_next = lfre_pkg::ST_IP_MUL;
        else               state_next = lfre_pkg::ST_SLEW;
      end
      lfre_pkg::ST_SLEW: begin
        cmd.slew   = 1'b1;
        state_next = lfre_pkg::ST_APPLY;
      end
      lfre_pkg::ST_IP_MUL: begin
        cmd.mul_sel = lfre_pkg::MUL_INTERP;
        if (sts.dur_zero) begin
          state_next = lfre_pkg::ST_IP_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = lfre_pkg::ST_IP_DIV;
        end
      end
      lfre_pkg::ST_IP_DIV: begin
        cmd.mul_sel = lfre_pkg::MUL_INTERP;
        if (sts.div_done) state_next = lfre_pkg::ST_IP_FIN;
      end
      lfre_pkg::ST_IP_FIN: begin
        cmd.mul_sel = lfre_pkg::MUL_INTERP;
        cmd.ip_fin  = 1'b1;
        if (ch == lfre_pkg::CH_SAT) begin
          state_next = lfre_pkg::ST_APPLY;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = lfre_pkg::ST_IP_MUL;
        end
      end
      lfre_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = lfre_pkg::ST_PUBLISH;
      end
      lfre_pkg::ST_PUBLISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = lfre_pkg::ST_IDLE;
        end
      end
      default: state_next = lfre_pkg::ST_IDLE;
    endcase
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == lfre_pkg::ST_TICK_DIV || state == lfre_pkg::ST_IP_DIV))
    else $error("divider finished outside a wait state");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> sts.out_free)
    else $error("result loaded over an untaken item");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch != 2'd3)
    else $error("channel index out of range");

  a_apply_then_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> state == lfre_pkg::ST_PUBLISH)
    else $error("step applied without publishing");

endmodule

[hdl/layer_fade_ramp_engine.sv]
// Top level of the layer fade ramp engine.
`timescale 1ns / 1ps
// Fade engine for one display layer: opacity, brightness and saturation.
// Input channel (in_valid/in_ready): a tick item (req_type 0) advances time
// and gives no result; a paint item (req_type 1) steps the channels and
// gives exactly one result item on the output channel (out_valid/out_ready).
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no item is in flight.
// Sequencing: one item at a time. A tick in constant-speed mode takes its step
// from the shared radix-2 divider unless the period is zero. A paint publishes
// at once when idle, skips the channel update with no step pending and
// otherwise slews; each unresponsive percent scaling adds a multiplier step.
// Constant-time mode runs the divider once per channel unless the duration is
// zero.
// in_ready is high only while the controller is idle.
// A finished result waits in the output register; the block keeps taking
// items meanwhile and only the next paint waits for that register to free.
// Reset: synchronous, active high; restores the configuration, channel state and
// controller state to their defaults and drops out_valid.
module layer_fade_ramp_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] elapsed_ms,
  input  logic [15:0] req_opacity,
  input  logic [15:0] req_brightness,
  input  logic [15:0] req_saturation,
  input  logic        owner_alive,
  input  logic        modal_active,
  input  logic        layer_is_modal,
  input  logic        closing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_opacity,
  output logic [15:0] out_brightness,
  output logic [15:0] out_saturation,
  output logic        needs_repaint,
  output logic        stopped
);

  lfre_pkg::cmd_t    cmd;
  lfre_pkg::status_t sts;

  lfre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfre_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .elapsed_ms     (elapsed_ms),
    .req_opacity    (req_opacity),
    .req_brightness (req_brightness),
    .req_saturation (req_saturation),
    .owner_alive    (owner_alive),
    .modal_active   (modal_active),
    .layer_is_modal (layer_is_modal),
    .closing        (closing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_opacity    (out_opacity),
    .out_brightness (out_brightness),
    .out_saturation (out_saturation),
    .needs_repaint  (needs_repaint),
    .stopped        (stopped)
  );

endmodule

[verif/tb_layer_fade_ramp_engine.sv]
// Testbench for the layer fade ramp engine: predicts each paint frame and checks it.
`timescale 1ns / 1ps

module tb_layer_fade_ramp_engine;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PAINT = 1'b1;
  localparam logic MODE_SPEED = 1'b0;
  localparam logic MODE_TIME = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic        kind;
    logic [15:0] elapsed;
    logic [15:0] opa;
    logic [15:0] bri;
    logic [15:0] sat;
    logic        alive;
    logic        modal;
    logic        self_modal;
    logic        closing;
  } fade_req_t;

  typedef struct {
    logic [15:0] opa;
    logic [15:0] bri;
    logic [15:0] sat;
    logic        repaint;
    logic        stop;
  } frame_t;

  class fade_scoreboard;
    int unsigned mode, period, duration, dim, bpct, spct, psat;
    int unsigned cur_o, cur_b, cur_s, goal_o, goal_b, goal_s;
    int          dlt_o, dlt_b, dlt_s;
    int unsigned step, time_left;
    frame_t      expected_frames[$];
    int          errors;

    function new();
      mode = 0; period = 100; duration = 100; dim = 0; bpct = 65; spct = 0; psat = 1;
      cur_o = 65535; cur_b = 65535; cur_s = 65535;
      goal_o = 65535; goal_b = 65535; goal_s = 65535;
      dlt_o = 0; dlt_b = 0; dlt_s = 0;
      step = 0; time_left = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned v);
      case (idx)
        lfre_pkg::CFG_RAMP_STYLE:  mode = v & 1;
        lfre_pkg::CFG_PERIOD:      period = v & 16'hFFFF;
        lfre_pkg::CFG_DURATION:    duration = v & 16'hFFFF;
        lfre_pkg::CFG_DIM_UNRESP:  dim = v & 1;
        lfre_pkg::CFG_UNRESP_BPCT: bpct = v & 7'h7F;
        lfre_pkg::CFG_UNRESP_SPCT: spct = v & 7'h7F;
        lfre_pkg::CFG_PSAT_OK:     psat = v & 1;
        default: ;
      endcase
    endfunction

    function int unsigned scale_pct(int unsigned v, int unsigned pct);
      int unsigned r;
      r = v * pct / 100;
      return (r > 65535) ? 65535 : r;
    endfunction

    function int unsigned slew(int unsigned cur, int unsigned tgt, int unsigned st);
      int unsigned n;
      if (tgt > cur) begin
        n = cur + st;
        return (n > tgt) ? tgt : n;
      end
      if (tgt < cur) begin
        n = (st >= cur) ? 0 : cur - st;
        return (n < tgt) ? tgt : n;
      end
      return cur;
    endfunction

    function longint lerp(int unsigned tgt, int d);
      if (duration == 0) return longint'(tgt);
      return longint'(tgt) - (longint'(d) * longint'(time_left)) / longint'(duration);
    endfunction

    function int unsigned clamp16(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return int'(v);
    endfunction

    function void note_item(fade_req_t r);
      int unsigned to, tb, ts, nb, ns;
      longint      no, st;
      frame_t      f;
      f.repaint = 1'b0;
      f.stop = 1'b0;
      if (r.kind == REQ_TICK) begin
        if (mode == MODE_SPEED) begin
          if (period == 0) st = 65535;
          else begin
            st = (longint'(r.elapsed) * 65535) / period;
            if (st > 65535) st = 65535;
          end
          step = (st < 12) ? 12 : int'(st);
          time_left = 0;
        end else if (time_left != 0) begin
          step = 1;
          time_left = (r.elapsed >= time_left) ? 0 : time_left - r.elapsed;
        end else begin
          step = 0;
        end
        return;
      end
      if (psat == 0) cur_s = r.sat;
      if (!r.alive || r.closing || r.modal || cur_o != r.opa || cur_b != r.bri ||
          cur_s != r.sat) begin
        to = r.opa; tb = r.bri; ts = r.sat;
        if (!r.alive && dim != 0) begin
          if (bpct != 100) tb = scale_pct(tb, bpct);
          if (spct != 100 && psat != 0) ts = scale_pct(ts, spct);
        end else if (r.modal && !r.self_modal) begin
          tb = lfre_pkg::MODAL_BRIGHT;
          ts = 0;
        end
        if (r.closing) to = 0;
        if (mode == MODE_TIME && (to != goal_o || tb != goal_b || ts != goal_s)) begin
          time_left = duration;
          step = 1;
          dlt_o = int'(to) - int'(cur_o);
          dlt_b = int'(tb) - int'(cur_b);
          dlt_s = int'(ts) - int'(cur_s);
          goal_o = to; goal_b = tb; goal_s = ts;
        end
        if (step != 0) begin
          if (mode == MODE_SPEED) begin
            no = slew(cur_o, to, step);
            nb = slew(cur_b, tb, step / 12);
            ns = slew(cur_s, ts, step / 6);
          end else begin
            no = lerp(to, dlt_o);
            nb = clamp16(lerp(tb, dlt_b));
            ns = clamp16(lerp(ts, dlt_s));
          end
          step = 0;
          if (no > 0) begin
            cur_o = clamp16(no);
            cur_b = nb;
            cur_s = ns;
            if (cur_o != to || nb != tb || ns != ts) f.repaint = 1'b1;
          end else begin
            cur_o = 0;
            f.stop = 1'b1;
          end
        end
      end
      f.opa = cur_o[15:0];
      f.bri = cur_b[15:0];
      f.sat = cur_s[15:0];
      expected_frames.push_back(f);
    endfunction

    function void check_frame(frame_t a);
      frame_t e;
      if (expected_frames.size() == 0) begin
        $error("unexpected result item: opacity %0d", a.opa);
        errors++;
        return;
      end
      e = expected_frames.pop_front();
      if (a.opa !== e.opa) begin
        $error("out_opacity expected %0d actual %0d", e.opa, a.opa); errors++;
      end
      if (a.bri !== e.bri) begin
        $error("out_brightness expected %0d actual %0d", e.bri, a.bri); errors++;
      end
      if (a.sat !== e.sat) begin
        $error("out_saturation expected %0d actual %0d", e.sat, a.sat); errors++;
      end
      if (a.repaint !== e.repaint) begin
        $error("needs_repaint expected %0d actual %0d", e.repaint, a.repaint); errors++;
      end
      if (a.stop !== e.stop) begin
        $error("stopped expected %0d actual %0d", e.stop, a.stop); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready;
  logic        req_type;
  logic [15:0] elapsed_ms, req_opacity, req_brightness, req_saturation;
  logic        owner_alive, modal_active, layer_is_modal, closing;
  logic        out_valid, out_ready;
  logic [15:0] out_opacity, out_brightness, out_saturation;
  logic        needs_repaint, stopped;

  fade_scoreboard sb;
  int  cycle_count;
  bit  long_hold;
  bit  started;

  layer_fade_ramp_engine dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // accepted input items feed the predictor, accepted frames are checked
  always @(posedge clk) begin
    fade_req_t r;
    frame_t    a;
    if (!rst && in_valid && in_ready) begin
      r.kind = req_type; r.elapsed = elapsed_ms;
      r.opa = req_opacity; r.bri = req_brightness; r.sat = req_saturation;
      r.alive = owner_alive; r.modal = modal_active;
      r.self_modal = layer_is_modal; r.closing = closing;
      sb.note_item(r);
    end
    if (!rst && out_valid && out_ready) begin
      a.opa = out_opacity; a.bri = out_brightness; a.sat = out_saturation;
      a.repaint = needs_repaint; a.stop = stopped;
      sb.check_frame(a);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    wait (started);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_item(fade_req_t r, bit allow_gap);
    int gap;
    in_valid <= 1'b1;
    req_type <= r.kind; elapsed_ms <= r.elapsed;
    req_opacity <= r.opa; req_brightness <= r.bri; req_saturation <= r.sat;
    owner_alive <= r.alive; modal_active <= r.modal;
    layer_is_modal <= r.self_modal; closing <= r.closing;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (allow_gap && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(int unsigned m, int unsigned p, int unsigned d, int unsigned dm,
                               int unsigned bp, int unsigned sp, int unsigned ps);
    int unsigned v[7];
    v = '{m, p, d, dm, bp, sp, ps};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 16'(v[i]);
      sb.set_reg(3'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fade_req_t tick_req(logic [15:0] ms);
    fade_req_t r;
    r = '{REQ_TICK, ms, 16'($urandom), 16'($urandom), 16'($urandom),
          1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)};
    return r;
  endfunction

  function automatic fade_req_t paint_req(logic [15:0] o, logic [15:0] b, logic [15:0] s,
                                          logic al, logic mo, logic sm, logic cl);
    fade_req_t r;
    r = '{REQ_PAINT, 16'($urandom), o, b, s, al, mo, sm, cl};
    return r;
  endfunction

  function automatic logic [15:0] pick_value(int unsigned cur);
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return 16'(cur);
    if (k == 4) return 16'h0000;
    if (k == 5) return 16'hFFFF;
    if (k == 6) return 16'(cur + $urandom_range(0, 600) - 300);
    return 16'($urandom);
  endfunction

  // mostly realistic frames: a random mix of ticks and paints, paint requests often at or near the current values
  function automatic fade_req_t random_req();
    logic [15:0] ms;
    if ($urandom_range(0, 99) < 45) begin
      case ($urandom_range(0, 9))
        0: ms = 16'($urandom);
        1: ms = 16'h0000;
        2: ms = 16'hFFFF;
        default: ms = 16'($urandom_range(1, 40));
      endcase
      return tick_req(ms);
    end
    return paint_req(pick_value(sb.cur_o), pick_value(sb.cur_b), pick_value(sb.cur_s),
                     $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 15,
                     1'($urandom), $urandom_range(0, 99) < 10);
  endfunction

  initial begin
    int unsigned st[8][7];
    sb = new();
    cycle_count = 0;
    long_hold = 1'b0;
    started = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; req_type <= REQ_TICK; elapsed_ms <= '0;
    req_opacity <= '0; req_brightness <= '0; req_saturation <= '0;
    owner_alive <= 1'b1; modal_active <= 1'b0; layer_is_modal <= 1'b0; closing <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    started = 1'b1;

    // directed: idle paint, no step pending, tick extremes, modal, self-modal and unresponsive dimming paths
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1);
    send_item(paint_req(16'h0000, 16'h1234, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1);
    send_item(tick_req(16'h0000), 1'b1);
    send_item(paint_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1);
    send_item(tick_req(16'hFFFF), 1'b1);
    send_item(paint_req(16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0), 1'b1);
    send_item(tick_req(16'd50), 1'b1);
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0), 1'b1);
    send_item(tick_req(16'd5), 1'b1);
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    drain_block();
    load_settings(MODE_SPEED, 100, 100, 1, 127, 100, 1);
    send_item(tick_req(16'd30), 1'b0);
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0);
    send_item(tick_req(16'hFFFF), 1'b0);
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1), 1'b0);
    send_item(paint_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1), 1'b0);

    st[0] = '{MODE_SPEED, 100, 100, 0, 65, 0, 1};
    st[1] = '{MODE_SPEED, 1, 100, 1, 100, 100, 1};
    st[2] = '{MODE_SPEED, 65535, 1, 1, 0, 127, 0};
    st[3] = '{MODE_TIME, 100, 50, 1, 50, 30, 1};
    st[4] = '{MODE_TIME, 0, 0, 0, 127, 100, 0};
    st[5] = '{MODE_TIME, 65535, 65535, 1, 0, 0, 1};
    st[6] = '{MODE_TIME, 7, 3, 1, 100, 101, 1};
    st[7] = '{MODE_SPEED, 0, 20, 1, 33, 66, 1};
    for (int ph = 0; ph < 8; ph++) begin
      drain_block();
      load_settings(st[ph][0], st[ph][1], st[ph][2], st[ph][3], st[ph][4], st[ph][5],
                    st[ph][6]);
      for (int i = 0; i < 220; i++) begin
        if (ph == 1 && i == 20) long_hold = 1'b1;
        send_item(random_req(), i % 50 > 10);
      end
    end

    drain_block();
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[layer_fade_ramp_engine.f]
hdl/lfre_pkg.sv
hdl/lfre_div.sv
hdl/lfre_dp.sv
hdl/lfre_ctrl.sv
hdl/layer_fade_ramp_engine.sv
verif/tb_layer_fade_ramp_engine.sv
